FILE: rtl/mps_pkg.sv
// Package: shared types and codes for the multi-slot parameter slide block.
`default_nettype none
package mps_pkg;

	// Operation codes of a request
	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_TWEAK  = 2'd1;
	localparam logic [1:0] OP_SLIDE  = 2'd2;

	// Configuration register indices
	localparam logic [1:0] REG_PERIOD = 2'd0;
	localparam logic [1:0] REG_SPT    = 2'd1;
	localparam logic [1:0] REG_PCOUNT = 2'd2;

	localparam int FRAC_BITS = 15;
	localparam int DIV_BITS  = 49;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TWEAK,
		ST_FIND_RD,
		ST_FIND_CHK,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_WALK_RD,
		ST_WALK_EX,
		ST_WALK_EM
	} state_t;

	// One slot entry, signed 17.15 values
	typedef struct packed {
		logic [7:0]         param;
		logic signed [31:0] value;
		logic signed [31:0] goal;
		logic signed [31:0] step;
	} slot_t;

endpackage
`default_nettype wire

FILE: rtl/mps_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module mps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/multi_slot_parameter_slide_core.sv
// Top level: multi-slot linear parameter slide engine.
// Flow: a direct tweak result passes through ST_TWEAK into the output registers; a sample step
//   emits one result per moving slot, each slot passing ST_WALK_RD, ST_WALK_EX and ST_WALK_EM.
// Throughput: one request at a time; a slide start holds busy through the multiply, divider
//   and write-back states (ST_MUL, ST_DIV, ST_FIN), with the bit-serial 49-step divider for the
//   step size, after the slot search (ST_FIND_RD, ST_FIND_CHK) while a slide is running.
// Reset (arst_n low) clears control state and slot busy flags; slot RAM needs no clear.
// Results cannot be stalled: strobe is high for exactly one cycle per result.
`default_nettype none
module multi_slot_parameter_slide_core #(
	parameter int SLOTS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         operation,
	input  wire logic [7:0]         param_index,
	input  wire logic [15:0]        target_raw,
	input  wire logic signed [16:0] param_min,
	input  wire logic signed [16:0] param_max,
	input  wire logic signed [16:0] present_value,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	output logic                    strobe,
	output logic [7:0]              out_param,
	output logic signed [17:0]      out_value,
	output logic                    last
);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int EW = $bits(mps_pkg::slot_t);

	mps_pkg::state_t state_q, state_d;

	// configuration
	logic [15:0] period_q, spt_q;
	logic [8:0]  pcount_q;

	// slide control
	logic              active_q;
	logic [15:0]       cd_q;
	logic [SLOTS-1:0]  busy_q;
	logic [SW:0]       slot_q;
	logic              moving_q;
	logic              found_q;
	logic [SW-1:0]     free_q, chosen_q;

	// latched request
	logic [7:0]         idx_q;
	logic signed [17:0] goal18_q;
	logic signed [16:0] cur_q;

	// step computation
	logic [33:0]          mul_q;
	logic                 neg_q, dnz_q;
	logic [15:0]          rem_q;
	logic [mps_pkg::DIV_BITS-1:0] dq_q;
	logic [5:0]           cnt_q;

	// walk result
	logic signed [32:0] v_q;
	logic [7:0]         vparam_q;
	logic               vlast_q;

	// output registers
	logic               strobe_q, last_q;
	logic [7:0]         oparam_q;
	logic signed [17:0] ovalue_q;

	// RAM
	logic              ram_we;
	logic [SW-1:0]     ram_waddr, ram_raddr;
	mps_pkg::slot_t    ram_wdata, ram_rdata;
	logic [EW-1:0]     ram_rbits;

	mps_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rbits)
	);
	assign ram_rdata = mps_pkg::slot_t'(ram_rbits);

	// --- shared combinational values ---
	logic               accept;
	logic               idx_ok;
	logic signed [18:0] sum19;
	logic signed [17:0] clamp18;
	logic [15:0]        per_eff, spt_eff;
	logic [SW-1:0]      si;
	logic               slot_end;
	logic signed [18:0] d0;
	logic [17:0]        dmag;
	logic [16:0]        rem_t;
	logic               qbit;
	logic [30:0]        mag31;
	logic signed [31:0] step_raw, step_fin;
	logic signed [32:0] v_sum, goal33;
	logic               snap;
	logic signed [32:0] v_tr;

	assign accept   = start && !busy;
	assign idx_ok   = {1'b0, param_index} < pcount_q;
	assign per_eff  = (period_q == '0) ? 16'd1 : period_q;
	assign spt_eff  = (spt_q == '0) ? 16'd1 : spt_q;
	assign si       = slot_q[SW-1:0];
	assign slot_end = slot_q == (SW+1)'(SLOTS);

	// offset by minimum, clamp to maximum
	assign sum19   = $signed({3'b000, target_raw}) + 19'(param_min);
	assign clamp18 = (sum19 > 19'(param_max)) ? 18'(param_max) : sum19[17:0];

	// goal minus present, integer part
	assign d0   = 19'(goal18_q) - 19'(cur_q);
	assign dmag = d0[18] ? 18'(-d0) : d0[17:0];

	// restoring divider step
	assign rem_t = {rem_q, dq_q[mps_pkg::DIV_BITS-1]};
	assign qbit  = rem_t >= {1'b0, spt_eff};

	// saturate, sign and force a minimum step of one LSB
	assign mag31    = (|dq_q[mps_pkg::DIV_BITS-1:31]) ? 31'h7FFF_FFFF : dq_q[30:0];
	assign step_raw = neg_q ? -$signed({1'b0, mag31}) : $signed({1'b0, mag31});
	assign step_fin = (mag31 == '0 && dnz_q) ? (neg_q ? -32'sd1 : 32'sd1) : step_raw;

	// advance one slot
	assign v_sum  = 33'(ram_rdata.value) + 33'(ram_rdata.step);
	assign goal33 = 33'(ram_rdata.goal);
	assign snap   = ram_rdata.step[31] ? (v_sum <= goal33) : (v_sum >= goal33);

	// truncate toward zero
	assign v_tr = v_q + (v_q[32] ? 33'sd32767 : 33'sd0);

	// --- next state ---
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mps_pkg::ST_IDLE: begin
				if (accept) begin
					case (operation)
						mps_pkg::OP_SAMPLE: begin
							if (active_q && cd_q <= 16'd1) state_d = mps_pkg::ST_WALK_RD;
						end
						mps_pkg::OP_TWEAK: begin
							if (idx_ok) state_d = mps_pkg::ST_TWEAK;
						end
						mps_pkg::OP_SLIDE: begin
							if (idx_ok) state_d = active_q ? mps_pkg::ST_FIND_RD : mps_pkg::ST_MUL;
						end
						default: state_d = mps_pkg::ST_IDLE;
					endcase
				end
			end
			mps_pkg::ST_TWEAK: state_d = mps_pkg::ST_IDLE;
			mps_pkg::ST_FIND_RD: begin
				if (slot_end) state_d = found_q ? mps_pkg::ST_MUL : mps_pkg::ST_TWEAK;
				else if (busy_q[si]) state_d = mps_pkg::ST_FIND_CHK;
			end
			mps_pkg::ST_FIND_CHK: begin
				state_d = (ram_rdata.param == idx_q) ? mps_pkg::ST_MUL : mps_pkg::ST_FIND_RD;
			end
			mps_pkg::ST_MUL: state_d = mps_pkg::ST_DIV;
			mps_pkg::ST_DIV: begin
				// load cycle, then one cycle per dividend bit
				if (cnt_q == 6'(mps_pkg::DIV_BITS)) state_d = mps_pkg::ST_FIN;
			end
			mps_pkg::ST_FIN: state_d = mps_pkg::ST_IDLE;
			mps_pkg::ST_WALK_RD: begin
				if (slot_end) state_d = mps_pkg::ST_IDLE;
				else if (busy_q[si]) state_d = mps_pkg::ST_WALK_EX;
			end
			mps_pkg::ST_WALK_EX: state_d = mps_pkg::ST_WALK_EM;
			mps_pkg::ST_WALK_EM: state_d = mps_pkg::ST_WALK_RD;
			default: state_d = mps_pkg::ST_IDLE;
		endcase
	end

	// --- RAM port and handshake outputs ---
	always_comb begin
		busy      = state_q != mps_pkg::ST_IDLE;
		ram_raddr = si;
		ram_we    = 1'b0;
		ram_waddr = si;
		ram_wdata = ram_rdata;
		case (state_q)
			mps_pkg::ST_FIN: begin
				ram_we          = 1'b1;
				ram_waddr       = chosen_q;
				ram_wdata.param = idx_q;
				ram_wdata.value = {cur_q, 15'b0};
				ram_wdata.goal  = {goal18_q[16:0], 15'b0};
				ram_wdata.step  = step_fin;
			end
			mps_pkg::ST_WALK_EX: begin
				ram_we          = 1'b1;
				ram_wdata.value = snap ? ram_rdata.goal : v_sum[31:0];
			end
			default: ram_we = 1'b0;
		endcase
	end

	// --- control registers ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mps_pkg::ST_IDLE;
			period_q <= 16'd64;
			spt_q    <= 16'd1000;
			pcount_q <= 9'd256;
			active_q <= 1'b0;
			cd_q     <= '0;
			busy_q   <= '0;
			slot_q   <= '0;
			moving_q <= 1'b0;
			found_q  <= 1'b0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					mps_pkg::REG_PERIOD: period_q <= cfg_data;
					mps_pkg::REG_SPT:    spt_q    <= cfg_data;
					mps_pkg::REG_PCOUNT: pcount_q <= cfg_data[8:0];
					default:             period_q <= period_q;
				endcase
			end
			case (state_q)
				mps_pkg::ST_IDLE: begin
					slot_q   <= '0;
					found_q  <= 1'b0;
					moving_q <= 1'b0;
					if (accept && operation == mps_pkg::OP_SAMPLE && active_q) begin
						if (cd_q > 16'd1) cd_q <= cd_q - 16'd1;
						else cd_q <= (cd_q == '0) ? per_eff - 16'd1 : per_eff;
					end
					// no slide running: every slot is free, take slot 0
					if (accept && operation == mps_pkg::OP_SLIDE && !active_q) begin
						busy_q <= '0;
					end
				end
				mps_pkg::ST_TWEAK: strobe_q <= 1'b1;
				mps_pkg::ST_FIND_RD: begin
					if (!slot_end && !busy_q[si]) begin
						found_q <= 1'b1;
						slot_q  <= slot_q + 1'b1;
					end
				end
				mps_pkg::ST_FIND_CHK: begin
					if (ram_rdata.param != idx_q) slot_q <= slot_q + 1'b1;
				end
				mps_pkg::ST_MUL: cnt_q <= '0;
				mps_pkg::ST_DIV: cnt_q <= cnt_q + 6'd1;
				mps_pkg::ST_FIN: begin
					busy_q[chosen_q] <= step_fin != '0;
					active_q         <= 1'b1;
					cd_q             <= '0;
				end
				mps_pkg::ST_WALK_RD: begin
					if (slot_end) active_q <= moving_q;
					else if (!busy_q[si]) slot_q <= slot_q + 1'b1;
				end
				mps_pkg::ST_WALK_EX: begin
					if (snap) busy_q[si] <= 1'b0;
					else moving_q <= 1'b1;
				end
				mps_pkg::ST_WALK_EM: begin
					strobe_q <= 1'b1;
					slot_q   <= slot_q + 1'b1;
				end
				default: strobe_q <= 1'b0;
			endcase
		end
	end

	// --- datapath registers ---
	always_ff @(posedge clk) begin
		case (state_q)
			mps_pkg::ST_IDLE: begin
				idx_q    <= param_index;
				goal18_q <= clamp18;
				cur_q    <= present_value;
				chosen_q <= '0;
			end
			mps_pkg::ST_TWEAK: begin
				oparam_q <= idx_q;
				ovalue_q <= goal18_q;
				last_q   <= 1'b1;
			end
			mps_pkg::ST_FIND_RD: begin
				if (!slot_end && !busy_q[si] && !found_q) free_q <= si;
				if (slot_end) chosen_q <= free_q;
			end
			mps_pkg::ST_FIND_CHK: begin
				if (ram_rdata.param == idx_q) chosen_q <= si;
			end
			mps_pkg::ST_MUL: begin
				mul_q <= dmag * per_eff;
				neg_q <= d0[18];
				dnz_q <= d0 != '0;
				rem_q <= '0;
			end
			mps_pkg::ST_DIV: begin
				if (cnt_q == '0) begin
					// first step loads the dividend: |diff| * period in 34.15
					dq_q <= {mul_q, 15'b0};
				end else begin
					rem_q <= qbit ? 16'(rem_t - {1'b0, spt_eff}) : rem_t[15:0];
					dq_q  <= {dq_q[mps_pkg::DIV_BITS-2:0], qbit};
				end
			end
			mps_pkg::ST_WALK_EX: begin
				v_q      <= snap ? goal33 : v_sum;
				vparam_q <= ram_rdata.param;
				vlast_q  <= ((busy_q >> si) >> 1) == '0;
			end
			mps_pkg::ST_WALK_EM: begin
				oparam_q <= vparam_q;
				ovalue_q <= 18'(v_tr >>> mps_pkg::FRAC_BITS);
				last_q   <= vlast_q;
			end
			default: ;
		endcase
	end

	assign strobe    = strobe_q;
	assign out_param = oparam_q;
	assign out_value = ovalue_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	// a moving slot always implies a running slide
	a_busy_active: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q != '0) |-> active_q) else $error("slot busy while slide idle");
	// results only come from the tweak or walk emit states
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> ($past(state_q) == mps_pkg::ST_TWEAK
			|| $past(state_q) == mps_pkg::ST_WALK_EM)) else $error("stray result");
	// divider never runs past its last step
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mps_pkg::ST_DIV) |-> (cnt_q <= 6'(mps_pkg::DIV_BITS)))
		else $error("divider overrun");
`endif

endmodule
`default_nettype wire
